// ===== design/segmented_sieve_prime_race_unit_defines.svh =====
// Assertion macros shared by the segmented sieve prime race unit.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SEGMENTED_SIEVE_PRIME_RACE_UNIT_DEFINES_SVH
`define SEGMENTED_SIEVE_PRIME_RACE_UNIT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SSPRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SSPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ssprc_pkg.sv =====
// Types and constants of the segmented sieve prime race unit.
// Used by the interfaces, the divider and the top level; no dependencies.
`timescale 1ns / 1ps

package ssprc_pkg;

    localparam int NUM_W  = 48;
    localparam int PRIME_W = 32;
    localparam int RES_W  = 16;
    localparam int FLIP_W = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SEG   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_RES_A   = 2'd1;
    localparam logic [1:0] CFG_RES_B   = 2'd2;
    localparam logic [1:0] CFG_LIMIT   = 2'd3;

    localparam logic signed [1:0] LEAD_NONE = 2'sb00;
    localparam logic signed [1:0] LEAD_B    = 2'sb01;
    localparam logic signed [1:0] LEAD_A    = 2'sb11;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_P_RD,
        S_P_LAT,
        S_P_DIV,
        S_P_CLAMP,
        S_MARK,
        S_R_DIV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FINISH,
        S_DONE
    } t_state;

endpackage

// ===== design/ssprc_in_if.sv =====
// Input channel of the segmented sieve prime race unit.
// Depends on ssprc_pkg for field widths.
`timescale 1ns / 1ps

interface ssprc_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      opcode;
    logic [ssprc_pkg::PRIME_W-1:0]   prime_value;
    logic [ssprc_pkg::NUM_W-1:0]     segment_low;

    modport source (output valid, opcode, prime_value, segment_low, input ready);
    modport sink (input valid, opcode, prime_value, segment_low, output ready);
endinterface

// ===== design/ssprc_out_if.sv =====
// Result channel of the segmented sieve prime race unit.
// Depends on ssprc_pkg for field widths.
`timescale 1ns / 1ps

interface ssprc_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [ssprc_pkg::NUM_W-1:0]   segment_high;
    logic [ssprc_pkg::NUM_W-1:0]   count_first;
    logic [ssprc_pkg::NUM_W-1:0]   count_second;
    logic signed [1:0]             leader;
    logic                          reversal_here;
    logic [ssprc_pkg::FLIP_W-1:0]  reversal_total;
    logic [ssprc_pkg::NUM_W-1:0]   first_reversal_at;

    modport source (output valid, status, segment_high, count_first, count_second, leader,
                    reversal_here, reversal_total, first_reversal_at, input ready);
    modport sink (input valid, status, segment_high, count_first, count_second, leader,
                  reversal_here, reversal_total, first_reversal_at, output ready);
endinterface

// ===== design/ssprc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssprc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/ssprc_div.sv =====
// Bit-serial restoring divider that returns the remainder of a 48-bit value
// by a 32-bit divisor, one quotient bit per cycle. Depends on ssprc_pkg.
`timescale 1ns / 1ps

module ssprc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ssprc_pkg::NUM_W-1:0]   i_dividend,
    input  logic [ssprc_pkg::PRIME_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [ssprc_pkg::PRIME_W-1:0] o_rem
);
    localparam int CW = $clog2(ssprc_pkg::NUM_W);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [ssprc_pkg::NUM_W-1:0]   r_dvd, n_dvd;
    logic [ssprc_pkg::PRIME_W-1:0] r_dsr, n_dsr;
    logic [ssprc_pkg::PRIME_W-1:0] r_rem, n_rem;
    logic [ssprc_pkg::PRIME_W:0]   trial;
    logic [ssprc_pkg::PRIME_W:0]   diff;

    always_comb begin
        trial  = {r_rem, r_dvd[ssprc_pkg::NUM_W-1]};
        diff   = trial - {1'b0, r_dsr};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(ssprc_pkg::NUM_W - 1);
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = (trial >= {1'b0, r_dsr}) ? diff[ssprc_pkg::PRIME_W-1:0]
                                             : trial[ssprc_pkg::PRIME_W-1:0];
            n_dvd = {r_dvd[ssprc_pkg::NUM_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== design/segmented_sieve_prime_race_unit.sv =====
// Segmented sieve prime race unit: one sequencer over a shared divider,
// a prime table RAM and a composite bitmap RAM.
// Usage notes:
//   Words arrive on i_item (opcode, prime_value, segment_low) and one result
//   word per item leaves on o_result. Configuration registers are written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   A load word appends a prime (status 1 when the table is full); a clear
//   word empties the table and zeroes the race counters; a segment word
//   sieves [segment_low, min(segment_low+SEG_LEN-1, limit)] and counts the
//   primes of the two residue classes.
//   Load, clear and unused opcodes go straight to the done state. A segment
//   word reads each table entry, has the serial divider reduce segment_low
//   by each entry of two or more, raises the first multiple to the square
//   and marks the multiples through the bitmap write port; then, unless the
//   modulus is zero, the divider gives the residue of segment_low, and the
//   scan reads the bitmap in S_SCAN_RD and counts in S_SCAN_EV, clearing it
//   behind itself. After reset the bitmap is cleared entry by entry, during
//   which no word is accepted. The done state loads a finished result into
//   the output register once that is free; the next word is taken meanwhile,
//   and its result waits until the receiver takes the previous one. Depends
//   on ssprc_pkg, the interfaces, ssprc_ram, ssprc_div and the defines header.
`timescale 1ns / 1ps
`include "segmented_sieve_prime_race_unit_defines.svh"

module segmented_sieve_prime_race_unit #(
    parameter int SEG_LEN     = 65536,
    parameter int PRIME_SLOTS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ssprc_in_if.sink                    i_item,
    ssprc_out_if.source                 o_result,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [ssprc_pkg::NUM_W-1:0] i_cfg_data
);
    localparam int SAW = $clog2(SEG_LEN);
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int PCW = PAW + 1;
    localparam int NW  = ssprc_pkg::NUM_W;
    localparam int PW  = ssprc_pkg::PRIME_W;
    localparam int RW  = ssprc_pkg::RES_W;
    localparam int FW  = ssprc_pkg::FLIP_W;
    localparam int JW  = 2 * PW;

    ssprc_pkg::t_state r_state, n_state;

    logic [RW-1:0]  r_mod, r_res_a, r_res_b;
    logic [NW-1:0]  r_limit;
    logic [PCW-1:0] r_pcount, n_pcount;
    logic [PCW-1:0] r_idx, n_idx;
    logic [SAW-1:0] r_clr, n_clr;
    logic [NW-1:0]  r_lo, n_lo;
    logic [NW-1:0]  r_hi, n_hi;
    logic [NW-1:0]  r_n, n_n;
    logic [RW-1:0]  r_res, n_res;
    logic [PW-1:0]  r_p, n_p;
    logic [JW-1:0]  r_psq, n_psq;
    logic [JW-1:0]  r_j, n_j;
    logic [NW-1:0]  r_tally_a, n_tally_a, r_tally_b, n_tally_b;
    logic signed [1:0] r_last, n_last;
    logic [FW-1:0]  r_flips, n_flips;
    logic [NW-1:0]  r_first_end, n_first_end;
    logic [1:0]     r_status, n_status;
    logic [NW-1:0]  r_seg_hi, n_seg_hi;
    logic           r_here, n_here;

    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_o_status;
    logic [NW-1:0]  r_o_seg_hi, r_o_cnt_a, r_o_cnt_b, r_o_first;
    logic signed [1:0] r_o_lead;
    logic           r_o_here;
    logic [FW-1:0]  r_o_flips;
    logic           load_out;

    logic           pt_we;
    logic [PAW-1:0] pt_raddr;
    logic [PW-1:0]  pt_rdata;
    logic           bm_we;
    logic [SAW-1:0] bm_waddr, bm_raddr;
    logic           bm_wdata;
    logic           bm_rdata;

    logic           div_start, div_done;
    logic [NW-1:0]  div_dividend;
    logic [PW-1:0]  div_divisor, div_rem;

    logic           accept;
    logic [NW:0]    seg_end;
    logic [NW-1:0]  scan_off;
    logic [JW-1:0]  mark_off;
    logic signed [1:0] lead_now;
    logic           is_prime, hit_a, hit_b;
    logic [RW:0]    res_inc;

    ssprc_ram #(.WIDTH(PW), .DEPTH(PRIME_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_pcount[PAW-1:0]),
        .i_wdata (i_item.prime_value),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    ssprc_ram #(.WIDTH(1), .DEPTH(SEG_LEN)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    ssprc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign accept         = i_item.valid && i_item.ready;
    assign i_item.ready   = (r_state == ssprc_pkg::S_IDLE);
    assign seg_end        = {1'b0, i_item.segment_low} + (NW+1)'(SEG_LEN - 1);
    assign scan_off       = r_n - r_lo;
    assign mark_off       = r_j - {{(JW-NW){1'b0}}, r_lo};
    assign pt_raddr       = r_idx[PAW-1:0];
    assign bm_raddr       = scan_off[SAW-1:0];
    assign div_dividend   = r_lo;
    assign div_divisor    = (r_state == ssprc_pkg::S_P_LAT) ? pt_rdata
                                                            : {{(PW-RW){1'b0}}, r_mod};
    assign res_inc        = {1'b0, r_res} + 1'b1;

    always_comb begin
        if (r_tally_b > r_tally_a) begin
            lead_now = ssprc_pkg::LEAD_B;
        end else if (r_tally_a > r_tally_b) begin
            lead_now = ssprc_pkg::LEAD_A;
        end else begin
            lead_now = ssprc_pkg::LEAD_NONE;
        end
    end

    // A modulus of zero compares the number itself against the residue.
    always_comb begin
        is_prime = (r_n >= NW'(2)) && !bm_rdata;
        if (r_mod == '0) begin
            hit_a = (r_n == {{(NW-RW){1'b0}}, r_res_a});
            hit_b = (r_n == {{(NW-RW){1'b0}}, r_res_b});
        end else begin
            hit_a = (r_res == r_res_a);
            hit_b = (r_res == r_res_b);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pcount    = r_pcount;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_n         = r_n;
        n_res       = r_res;
        n_p         = r_p;
        n_psq       = r_psq;
        n_j         = r_j;
        n_tally_a   = r_tally_a;
        n_tally_b   = r_tally_b;
        n_last      = r_last;
        n_flips     = r_flips;
        n_first_end = r_first_end;
        n_status    = r_status;
        n_seg_hi    = r_seg_hi;
        n_here      = r_here;
        pt_we       = 1'b0;
        bm_we       = 1'b0;
        bm_waddr    = scan_off[SAW-1:0];
        bm_wdata    = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;

        unique case (r_state)
            ssprc_pkg::S_INIT: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == SAW'(SEG_LEN - 1)) begin
                    n_state = ssprc_pkg::S_IDLE;
                end
            end
            ssprc_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = ssprc_pkg::ST_OK;
                    n_seg_hi = '0;
                    n_here   = 1'b0;
                    n_state  = ssprc_pkg::S_DONE;
                    unique case (i_item.opcode)
                        ssprc_pkg::OP_LOAD: begin
                            if (r_pcount == PCW'(PRIME_SLOTS)) begin
                                n_status = ssprc_pkg::ST_FULL;
                            end else begin
                                pt_we    = 1'b1;
                                n_pcount = r_pcount + 1'b1;
                            end
                        end
                        ssprc_pkg::OP_SEG: begin
                            if (i_item.segment_low > r_limit) begin
                                n_status = ssprc_pkg::ST_RANGE;
                            end else begin
                                n_lo    = i_item.segment_low;
                                n_n     = i_item.segment_low;
                                n_hi    = (seg_end > {1'b0, r_limit}) ? r_limit
                                                                      : seg_end[NW-1:0];
                                n_idx   = '0;
                                n_state = ssprc_pkg::S_P_RD;
                            end
                        end
                        ssprc_pkg::OP_CLEAR: begin
                            n_pcount    = '0;
                            n_tally_a   = '0;
                            n_tally_b   = '0;
                            n_last      = ssprc_pkg::LEAD_NONE;
                            n_flips     = '0;
                            n_first_end = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ssprc_pkg::S_P_RD: begin
                if (r_idx == r_pcount) begin
                    if (r_mod == '0) begin
                        n_res   = '0;
                        n_state = ssprc_pkg::S_SCAN_RD;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ssprc_pkg::S_R_DIV;
                    end
                end else begin
                    n_state = ssprc_pkg::S_P_LAT;
                end
            end
            ssprc_pkg::S_P_LAT: begin
                n_p   = pt_rdata;
                n_psq = pt_rdata * pt_rdata;
                n_idx = r_idx + 1'b1;
                if (pt_rdata < PW'(2)) begin
                    n_state = ssprc_pkg::S_P_RD;
                end else begin
                    div_start = 1'b1;
                    n_state   = ssprc_pkg::S_P_DIV;
                end
            end
            ssprc_pkg::S_P_DIV: begin
                if (div_done) begin
                    // First multiple at or above the segment start.
                    n_j = {{(JW-NW){1'b0}}, r_lo}
                        + ((div_rem == '0) ? '0 : {{(JW-PW){1'b0}}, r_p - div_rem});
                    n_state = ssprc_pkg::S_P_CLAMP;
                end
            end
            ssprc_pkg::S_P_CLAMP: begin
                if (r_j < r_psq) begin
                    n_j = r_psq;
                end
                n_state = ssprc_pkg::S_MARK;
            end
            ssprc_pkg::S_MARK: begin
                if (r_j <= {{(JW-NW){1'b0}}, r_hi}) begin
                    bm_we    = 1'b1;
                    bm_waddr = mark_off[SAW-1:0];
                    bm_wdata = 1'b1;
                    n_j      = r_j + {{(JW-PW){1'b0}}, r_p};
                end else begin
                    n_state = ssprc_pkg::S_P_RD;
                end
            end
            ssprc_pkg::S_R_DIV: begin
                if (div_done) begin
                    n_res   = div_rem[RW-1:0];
                    n_state = ssprc_pkg::S_SCAN_RD;
                end
            end
            ssprc_pkg::S_SCAN_RD: begin
                n_state = ssprc_pkg::S_SCAN_EV;
            end
            ssprc_pkg::S_SCAN_EV: begin
                // The scan leaves every entry it reads cleared for the next segment.
                bm_we = 1'b1;
                if (is_prime && hit_a && (r_tally_a != '1)) begin
                    n_tally_a = r_tally_a + 1'b1;
                end
                if (is_prime && hit_b && (r_tally_b != '1)) begin
                    n_tally_b = r_tally_b + 1'b1;
                end
                if (r_n == r_hi) begin
                    n_state = ssprc_pkg::S_FINISH;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_res   = (res_inc == {1'b0, r_mod}) ? '0 : res_inc[RW-1:0];
                    n_state = ssprc_pkg::S_SCAN_RD;
                end
            end
            ssprc_pkg::S_FINISH: begin
                n_seg_hi = r_hi;
                if ((lead_now != ssprc_pkg::LEAD_NONE) && (r_last != ssprc_pkg::LEAD_NONE)
                        && (lead_now != r_last)) begin
                    n_here = 1'b1;
                    if (r_flips == '0) begin
                        n_first_end = r_hi;
                    end
                    if (r_flips != '1) begin
                        n_flips = r_flips + 1'b1;
                    end
                end
                if (lead_now != ssprc_pkg::LEAD_NONE) begin
                    n_last = lead_now;
                end
                n_state = ssprc_pkg::S_DONE;
            end
            ssprc_pkg::S_DONE: begin
                if (!r_ovalid || o_result.ready) begin
                    load_out = 1'b1;
                    n_state  = ssprc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssprc_pkg::S_IDLE;
            end
        endcase
    end

    assign n_ovalid = (r_ovalid && !o_result.ready) || load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssprc_pkg::S_INIT;
            r_clr       <= '0;
            r_pcount    <= '0;
            r_tally_a   <= '0;
            r_tally_b   <= '0;
            r_last      <= ssprc_pkg::LEAD_NONE;
            r_flips     <= '0;
            r_first_end <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pcount    <= n_pcount;
            r_tally_a   <= n_tally_a;
            r_tally_b   <= n_tally_b;
            r_last      <= n_last;
            r_flips     <= n_flips;
            r_first_end <= n_first_end;
            r_ovalid    <= n_ovalid;
        end
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_n      <= n_n;
        r_res    <= n_res;
        r_p      <= n_p;
        r_psq    <= n_psq;
        r_j      <= n_j;
        r_status <= n_status;
        r_seg_hi <= n_seg_hi;
        r_here   <= n_here;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= RW'(4);
            r_res_a <= RW'(1);
            r_res_b <= RW'(3);
            r_limit <= NW'(1000000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssprc_pkg::CFG_MODULUS: r_mod   <= i_cfg_data[RW-1:0];
                ssprc_pkg::CFG_RES_A:   r_res_a <= i_cfg_data[RW-1:0];
                ssprc_pkg::CFG_RES_B:   r_res_b <= i_cfg_data[RW-1:0];
                ssprc_pkg::CFG_LIMIT:   r_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_status <= r_status;
            r_o_seg_hi <= r_seg_hi;
            r_o_cnt_a  <= r_tally_a;
            r_o_cnt_b  <= r_tally_b;
            r_o_lead   <= lead_now;
            r_o_here   <= r_here;
            r_o_flips  <= r_flips;
            r_o_first  <= r_first_end;
        end
    end

    assign o_result.valid             = r_ovalid;
    assign o_result.status            = r_o_status;
    assign o_result.segment_high      = r_o_seg_hi;
    assign o_result.count_first       = r_o_cnt_a;
    assign o_result.count_second      = r_o_cnt_b;
    assign o_result.leader            = r_o_lead;
    assign o_result.reversal_here     = r_o_here;
    assign o_result.reversal_total    = r_o_flips;
    assign o_result.first_reversal_at = r_o_first;

    `SSPRC_ASSERT_SAME(a_pcount_bound, i_clk, i_rst_n, 1'b1,
        r_pcount <= PCW'(PRIME_SLOTS), "prime count beyond table")
    `SSPRC_ASSERT_SAME(a_scan_in_seg, i_clk, i_rst_n, r_state == ssprc_pkg::S_SCAN_EV,
        (r_n >= r_lo) && (r_n <= r_hi), "scan outside segment")
    `SSPRC_ASSERT_NEXT(a_tally_a_mono, i_clk, i_rst_n, r_state != ssprc_pkg::S_IDLE,
        r_tally_a >= $past(r_tally_a), "first tally decreased")
    `SSPRC_ASSERT_NEXT(a_tally_b_mono, i_clk, i_rst_n, r_state != ssprc_pkg::S_IDLE,
        r_tally_b >= $past(r_tally_b), "second tally decreased")
    `SSPRC_ASSERT_SAME(a_mark_in_seg, i_clk, i_rst_n, bm_we && bm_wdata,
        mark_off < JW'(SEG_LEN), "mark outside segment")
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for segmented_sieve_prime_race_unit: drives load, segment, clear and
// reserved-opcode words with random idling, predicts every result word and compares them field by field.
// Depends on ssprc_pkg, ssprc_in_if, ssprc_out_if and the block itself.
`timescale 1ns / 1ps

module tb_top;

    localparam int SEG_SPAN   = 65536;
    localparam int TABLE_SIZE = 8192;
    localparam longint unsigned TOP48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]                    status;
        logic [ssprc_pkg::NUM_W-1:0]   seg_hi;
        logic [ssprc_pkg::NUM_W-1:0]   cnt_a;
        logic [ssprc_pkg::NUM_W-1:0]   cnt_b;
        logic signed [1:0]             lead;
        logic                          flip;
        logic [ssprc_pkg::FLIP_W-1:0]  flips;
        logic [ssprc_pkg::NUM_W-1:0]   first_flip;
    } t_race_result;

    class race_scoreboard;
        logic [ssprc_pkg::PRIME_W-1:0] primes[$];
        bit                 composite[0:SEG_SPAN-1];
        longint unsigned    tally_a, tally_b, flip_total, first_flip_end;
        longint unsigned    q_mod, res_a, res_b, limit;
        logic signed [1:0]  last_lead;
        t_race_result       pending[$];
        int                 errors, segments, flips_seen;

        function new();
            q_mod = 4; res_a = 1; res_b = 3; limit = 1000000;
            tally_a = 0; tally_b = 0; flip_total = 0; first_flip_end = 0;
            last_lead = ssprc_pkg::LEAD_NONE; errors = 0; segments = 0; flips_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [ssprc_pkg::NUM_W-1:0] data);
            case (idx)
                ssprc_pkg::CFG_MODULUS: q_mod = data[ssprc_pkg::RES_W-1:0];
                ssprc_pkg::CFG_RES_A:   res_a = data[ssprc_pkg::RES_W-1:0];
                ssprc_pkg::CFG_RES_B:   res_b = data[ssprc_pkg::RES_W-1:0];
                ssprc_pkg::CFG_LIMIT:   limit = data;
            endcase
        endfunction

        function logic signed [1:0] race_sign();
            if (tally_b > tally_a) return ssprc_pkg::LEAD_B;
            if (tally_a > tally_b) return ssprc_pkg::LEAD_A;
            return ssprc_pkg::LEAD_NONE;
        endfunction

        // Sieves one segment and updates the race; returns the segment end.
        function longint unsigned sieve_segment(longint unsigned lo, output bit flipped);
            longint unsigned hi, p, st, j, n, r;
            logic signed [1:0] now;
            hi = lo + SEG_SPAN - 1;
            if (hi > limit) hi = limit;
            for (longint unsigned k = 0; k <= hi - lo; k++) composite[k] = 0;
            foreach (primes[i]) begin
                p = primes[i];
                if (p < 2) continue;
                st = ((lo + p - 1) / p) * p;
                if (st < p * p) st = p * p;
                for (j = st; j <= hi; j += p) composite[j - lo] = 1;
            end
            for (n = lo; n <= hi; n++) begin
                if (n >= 2 && !composite[n - lo]) begin
                    r = (q_mod != 0) ? n % q_mod : n;
                    if (r == res_a && tally_a < TOP48) tally_a++;
                    if (r == res_b && tally_b < TOP48) tally_b++;
                end
            end
            now = race_sign();
            flipped = 0;
            if (now != ssprc_pkg::LEAD_NONE && last_lead != ssprc_pkg::LEAD_NONE
                    && now != last_lead) begin
                flipped = 1;
                if (flip_total == 0) first_flip_end = hi;
                if (flip_total < 64'hFFFF_FFFF) flip_total++;
            end
            if (now != ssprc_pkg::LEAD_NONE) last_lead = now;
            return hi;
        endfunction

        function void note_word(logic [1:0] op, logic [ssprc_pkg::PRIME_W-1:0] pv,
                                logic [ssprc_pkg::NUM_W-1:0] lo);
            t_race_result e;
            bit f;
            e.status = ssprc_pkg::ST_OK; e.seg_hi = '0; e.flip = 0;
            case (op)
                ssprc_pkg::OP_LOAD: begin
                    if (primes.size() >= TABLE_SIZE) e.status = ssprc_pkg::ST_FULL;
                    else primes.push_back(pv);
                end
                ssprc_pkg::OP_SEG: begin
                    if (lo > limit) begin
                        e.status = ssprc_pkg::ST_RANGE;
                    end else begin
                        e.seg_hi = sieve_segment(lo, f);
                        e.flip = f;
                        segments++;
                        flips_seen += f;
                    end
                end
                ssprc_pkg::OP_CLEAR: begin
                    primes.delete();
                    tally_a = 0; tally_b = 0; last_lead = ssprc_pkg::LEAD_NONE;
                    flip_total = 0; first_flip_end = 0;
                end
                default: ;
            endcase
            e.cnt_a = tally_a; e.cnt_b = tally_b; e.lead = race_sign();
            e.flips = flip_total; e.first_flip = first_flip_end;
            pending.push_back(e);
        endfunction

        function void field_cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, a);
            end
        endfunction

        function void check_result(t_race_result got);
            t_race_result e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got status %0d", $time,
                         got.status);
                return;
            end
            e = pending.pop_front();
            field_cmp("status", e.status, got.status);
            field_cmp("segment_high", e.seg_hi, got.seg_hi);
            field_cmp("count_first", e.cnt_a, got.cnt_a);
            field_cmp("count_second", e.cnt_b, got.cnt_b);
            field_cmp("leader", e.lead[1:0], got.lead[1:0]);
            field_cmp("reversal_here", e.flip, got.flip);
            field_cmp("reversal_total", e.flips, got.flips);
            field_cmp("first_reversal_at", e.first_flip, got.first_flip);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [1:0]                   cfg_idx;
    logic [ssprc_pkg::NUM_W-1:0]  cfg_data;
    bit                           hold_request;
    int                           words_sent;
    race_scoreboard               sb;

    ssprc_in_if  item_ch ();
    ssprc_out_if result_ch ();

    segmented_sieve_prime_race_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready)
            sb.note_word(item_ch.opcode, item_ch.prime_value, item_ch.segment_low);
    end

    always @(posedge i_clk) begin
        t_race_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.status = result_ch.status;
            got.seg_hi = result_ch.segment_high;
            got.cnt_a = result_ch.count_first;
            got.cnt_b = result_ch.count_second;
            got.lead = result_ch.leader;
            got.flip = result_ch.reversal_here;
            got.flips = result_ch.reversal_total;
            got.first_flip = result_ch.first_reversal_at;
            sb.check_result(got);
        end
    end

    // Receiver: random stalls per word, plus one long hold-off on request.
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        forever begin
            gap = $urandom_range(0, 7);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_request = 0;
            end else if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_word(logic [1:0] op, logic [ssprc_pkg::PRIME_W-1:0] pv,
                             logic [ssprc_pkg::NUM_W-1:0] lo);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.opcode <= op;
        item_ch.prime_value <= pv;
        item_ch.segment_low <= lo;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // The enable drops for one cycle after each write.
    task automatic write_reg(logic [1:0] idx, logic [ssprc_pkg::NUM_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper bits of the 16-bit registers are junk that the block must ignore.
    task automatic set_race(int q, int a, int b, longint unsigned lim);
        write_reg(ssprc_pkg::CFG_MODULUS, {$urandom_range(0, 65535), 16'(q)} << 0);
        write_reg(ssprc_pkg::CFG_RES_A, {16'($urandom), 16'($urandom), 16'(a)});
        write_reg(ssprc_pkg::CFG_RES_B, {16'($urandom), 16'($urandom), 16'(b)});
        write_reg(ssprc_pkg::CFG_LIMIT, lim[ssprc_pkg::NUM_W-1:0]);
    endtask

    task automatic random_phase(int count);
        int sel;
        longint unsigned lo;
        int small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_word(ssprc_pkg::OP_LOAD, $urandom, '0);
                end else begin
                    send_word(ssprc_pkg::OP_LOAD, small_primes[$urandom_range(0, 15)],
                              $urandom);
                end
            end else if (sel < 88) begin
                if ($urandom_range(0, 9) == 0 && sb.limit < TOP48)
                    lo = sb.limit + 1 + $urandom_range(0, 1000);
                else
                    lo = sb.limit - $urandom_range(0, 300);
                if (lo > TOP48) lo = TOP48;
                send_word(ssprc_pkg::OP_SEG, $urandom, lo[ssprc_pkg::NUM_W-1:0]);
            end else if (sel < 93) begin
                send_word(ssprc_pkg::OP_CLEAR, $urandom, $urandom);
            end else begin
                send_word(ssprc_pkg::OP_RSVD, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        longint unsigned lim;
        int seed_primes[6];
        seed_primes = '{2, 3, 5, 7, 11, 13};
        sb = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = ssprc_pkg::CFG_MODULUS;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = ssprc_pkg::OP_LOAD;
        item_ch.prime_value = '0;
        item_ch.segment_low = '0;
        hold_request = 0;
        words_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset settings: loads including entries below two and
        // the widest value, one full-length segment from zero, a clipped segment,
        // a start beyond the limit, clear, a segment with an empty table, opcode 3.
        send_word(ssprc_pkg::OP_RSVD, '1, '1);
        foreach (seed_primes[i]) send_word(ssprc_pkg::OP_LOAD, seed_primes[i], '0);
        send_word(ssprc_pkg::OP_LOAD, 32'd0, '0);
        send_word(ssprc_pkg::OP_LOAD, 32'd1, '0);
        send_word(ssprc_pkg::OP_LOAD, 32'hFFFF_FFFF, '0);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd0);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd1000001);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd999990);
        send_word(ssprc_pkg::OP_CLEAR, '0, '0);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd5);
        send_word(ssprc_pkg::OP_LOAD, 32'd2, '0);
        send_word(ssprc_pkg::OP_LOAD, 32'd3, '0);
        wait_drained();

        // A limit of two, then modulus zero with the largest limit.
        set_race(4, 1, 3, 2);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd0);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd2);
        send_word(ssprc_pkg::OP_SEG, '0, 48'd3);
        wait_drained();
        set_race(0, 65535, 0, TOP48);
        send_word(ssprc_pkg::OP_SEG, '0, TOP48[ssprc_pkg::NUM_W-1:0]);
        send_word(ssprc_pkg::OP_SEG, '0, 48'hFFFF_FFFF_FF00);
        wait_drained();

        set_race(4, 1, 3, $urandom_range(1000, 2000000));
        random_phase(16);
        wait_drained();
        set_race(4, 3, 1, sb.limit);
        random_phase(16);
        wait_drained();
        set_race($urandom_range(2, 10), 1, 0, TOP48 - $urandom_range(0, 500));
        write_reg(ssprc_pkg::CFG_RES_B, $urandom_range(0, sb.q_mod - 1));
        random_phase(16);
        wait_drained();
        lim = {$urandom, $urandom};
        lim = (lim & TOP48) | 64'h400;
        set_race(65535, $urandom_range(0, 65535), $urandom_range(0, 65535), lim);
        random_phase(16);
        wait_drained();
        set_race(3, 2, 1, $urandom_range(300, 100000));
        hold_request = 1;
        for (int k = 0; k < 8; k++) send_word(ssprc_pkg::OP_LOAD, $urandom_range(2, 40), '0);
        random_phase(16);
        wait_drained();

        $display("Covered %0d words, %0d sieved segments, %0d leader reversals.",
                 words_sent, sb.segments, sb.flips_seen);
        $display("Mismatches found: %0d.", sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ssprc_pkg.sv
design/ssprc_in_if.sv
design/ssprc_out_if.sv
design/ssprc_ram.sv
design/ssprc_div.sv
design/segmented_sieve_prime_race_unit.sv
tb/tb_top.sv
